// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by merge_sort_engine_top.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== design/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Types shared by the merge sort engine modules.
// ----------------------------------------------------------------------------
package mse_pkg;

    typedef logic signed [31:0] data_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MRD,
        ST_MWR,
        ST_ERD,
        ST_ELD,
        ST_EHOLD
    } state_t;

    // Result of one merge selection.
    typedef struct packed {
        logic  take_a;
        data_t value;
    } pick_t;

endpackage

// ===== design/merge_sort_engine_top.sv =====
// Load accepts one item per cycle. After the last item the sort makes bottom-up
// passes, each element being read (ST_MRD) and then compared and written
// (ST_MWR) once per pass; then the run is emitted, each item loaded (ST_ELD)
// and held (ST_EHOLD) until it is taken while out_stall is low.
// Reset clears control state only; the element banks need no clearing pass.
// ----------------------------------------------------------------------------
// merge_sort_engine_top
// Collects signed values into bank 0, bottom-up merge sorts them by
// ping-ponging between two banks, and streams the sorted run out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module merge_sort_engine_top
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  data_t value,
    input  logic  last,
    output logic  out_valid,
    input  logic  out_stall,
    output data_t sorted_value,
    output logic  final_res,
    output logic  overflow
);

    // CW holds a count up to MAX_ITEMS, AW addresses one entry.
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_ITEMS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t        state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;   // elements held
    logic          dropped_reg, dropped_next; // an item of this set was lost
    logic [CW-1:0] width_reg,   width_next;   // run width of current pass
    logic [CW-1:0] a_reg,       a_next;       // head of run A
    logic [CW-1:0] b_reg,       b_next;       // head of run B
    logic [CW-1:0] mid_reg,     mid_next;     // end of run A
    logic [CW-1:0] hi_reg,      hi_next;      // end of run B
    logic [CW-1:0] k_reg,       k_next;       // write slot / emit index
    logic          src_reg,     src_next;     // bank holding current runs
    data_t         out_data_reg, out_data_next;
    logic          out_valid_reg, out_valid_next;
    logic          final_reg,   final_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic          we0, we1;
    logic [AW-1:0] waddr;
    data_t         wdata;
    logic [AW-1:0] raddr0, raddr1;
    data_t         b0_rd0, b0_rd1, b1_rd0, b1_rd1;
    data_t         rd_a, rd_b;

    // Reads always come from the source bank and writes go to the other
    // one (or to bank 0 while loading), so a read and a write never touch
    // the same entry in one cycle and no forwarding is needed.
    mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank0
    (
        .clk    (clk),
        .we     (we0),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b0_rd0),
        .rdata1 (b0_rd1)
    );

    mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank1
    (
        .clk    (clk),
        .we     (we1),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b1_rd0),
        .rdata1 (b1_rd1)
    );

    assign rd_a = src_reg ? b1_rd0 : b0_rd0;
    assign rd_b = src_reg ? b1_rd1 : b0_rd1;

    // ------------------------------------------------------------------
    // Merge selection
    // ------------------------------------------------------------------
    pick_t pick;

    mse_pick #(.CW(CW)) u_pick
    (
        .a_val (rd_a),
        .b_val (rd_b),
        .a_idx (a_reg),
        .mid   (mid_reg),
        .b_idx (b_reg),
        .hi    (hi_reg),
        .pick  (pick)
    );

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    logic          in_acc;
    logic          room;
    logic [CW-1:0] n_load;      // set size once the current item is counted
    logic [CW:0]   k_inc;
    logic          pair_done;   // last slot of the current run pair
    logic          pass_done;   // last run pair of the pass
    logic [CW:0]   w_dbl;
    logic          sort_done;   // doubled width covers the whole set
    logic          out_take;

    assign in_acc    = in_valid && (state_reg == ST_LOAD);
    assign room      = count_reg < MAX_N;
    assign n_load    = room ? count_reg + CW'(1) : count_reg;
    assign k_inc     = {1'b0, k_reg} + (CW+1)'(1);
    assign pair_done = k_inc == {1'b0, hi_reg};
    assign pass_done = pair_done && (hi_reg == count_reg);
    assign w_dbl     = {width_reg, 1'b0};
    assign sort_done = w_dbl >= {1'b0, count_reg};
    assign out_take  = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Run pair geometry: mid = min(base + w, n), hi = min(base + 2w, n).
    // Used at the start of a sort, of a pass and of each run pair.
    // ------------------------------------------------------------------
    logic [CW-1:0] geo_base, geo_w, geo_n, geo_mid, geo_hi;
    logic [CW+1:0] sum1, sum2, n_ext;

    always_comb
    begin
        geo_n = count_reg;
        if (state_reg == ST_LOAD)
        begin
            geo_base = '0;
            geo_w    = CW'(1);
            geo_n    = n_load;
        end
        else if (pair_done && !pass_done)
        begin
            geo_base = hi_reg;
            geo_w    = width_reg;
        end
        else
        begin
            geo_base = '0;
            geo_w    = w_dbl[CW-1:0];
        end
        sum1    = {2'b00, geo_base} + {2'b00, geo_w};
        sum2    = sum1 + {2'b00, geo_w};
        n_ext   = {2'b00, geo_n};
        geo_mid = (sum1 > n_ext) ? geo_n : sum1[CW-1:0];
        geo_hi  = (sum2 > n_ext) ? geo_n : sum2[CW-1:0];
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && last)
                begin
                    // A single element is already sorted.
                    state_next = (n_load == CW'(1)) ? ST_ERD : ST_MRD;
                end
            end
            ST_MRD:
            begin
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                state_next = (pass_done && sort_done) ? ST_ERD : ST_MRD;
            end
            ST_ERD:
            begin
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                state_next = ST_EHOLD;
            end
            ST_EHOLD:
            begin
                if (out_take)
                begin
                    state_next = final_reg ? ST_LOAD : ST_ELD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        width_next     = width_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        final_next     = final_reg;
        in_stall       = 1'b1;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = k_reg[AW-1:0];
        wdata          = pick.value;
        raddr0         = k_reg[AW-1:0];
        raddr1         = b_reg[AW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                waddr    = count_reg[AW-1:0];
                wdata    = value;
                if (in_acc)
                begin
                    count_next = n_load;
                    if (room)
                    begin
                        we0 = 1'b1;
                    end
                    else
                    begin
                        // Full: the item is lost but a last marker still counts.
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        width_next = CW'(1);
                        a_next     = '0;
                        b_next     = geo_mid;
                        mid_next   = geo_mid;
                        hi_next    = geo_hi;
                        k_next     = '0;
                        src_next   = 1'b0;
                    end
                end
            end
            ST_MRD:
            begin
                // Fetch both run heads; B may point one past its run.
                raddr0 = a_reg[AW-1:0];
                raddr1 = b_reg[AW-1:0];
            end
            ST_MWR:
            begin
                we0 = src_reg;
                we1 = !src_reg;
                if (pass_done)
                begin
                    src_next = !src_reg;
                    k_next   = '0;
                    if (!sort_done)
                    begin
                        width_next = w_dbl[CW-1:0];
                        a_next     = '0;
                        b_next     = geo_mid;
                        mid_next   = geo_mid;
                        hi_next    = geo_hi;
                    end
                end
                else if (pair_done)
                begin
                    k_next   = k_inc[CW-1:0];
                    a_next   = hi_reg;
                    b_next   = geo_mid;
                    mid_next = geo_mid;
                    hi_next  = geo_hi;
                end
                else
                begin
                    k_next = k_inc[CW-1:0];
                    if (pick.take_a)
                    begin
                        a_next = a_reg + CW'(1);
                    end
                    else
                    begin
                        b_next = b_reg + CW'(1);
                    end
                end
            end
            ST_ERD:
            begin
                raddr0 = k_reg[AW-1:0];
            end
            ST_ELD:
            begin
                out_data_next  = rd_a;
                out_valid_next = 1'b1;
                final_next     = k_inc == {1'b0, count_reg};
            end
            ST_EHOLD:
            begin
                raddr0 = k_inc[AW-1:0];
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    if (final_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        k_next = k_inc[CW-1:0];
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg    <= width_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        src_reg      <= src_next;
        out_data_reg <= out_data_next;
        final_reg    <= final_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_data_reg;
    assign final_res    = final_reg;
    assign overflow     = dropped_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No item is taken while a sorted item is on offer.
    `ASSERT_IMP(a_no_load_on_emit, out_valid, in_stall)
    // The item that closes a set halts input at once.
    `ASSERT_NXT(a_last_blocks, in_valid && !in_stall && last, in_stall)
    // The merge never writes past the end of the set.
    `ASSERT_IMP(a_merge_in_range, state_reg == ST_MWR, k_reg < count_reg)
    // Taking the final item of a run clears the set.
    `ASSERT_NXT(a_final_clears, out_valid && !out_stall && final_res,
                !out_valid && !overflow && (count_reg == '0))

endmodule

// ===== design/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// Element bank: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mse_ram
    import mse_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  data_t         wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output data_t         rdata0,
    output data_t         rdata1
);

    data_t mem_reg [DEPTH];
    data_t rd0_reg;
    data_t rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd0_reg <= mem_reg[raddr0];
        rd1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ===== design/mse_pick.sv =====
// ----------------------------------------------------------------------------
// mse_pick
// Merge selection: picks the head of run A or run B for the next slot.
// ----------------------------------------------------------------------------
module mse_pick
    import mse_pkg::*;
#(
    parameter int CW = 7
)
(
    input  data_t         a_val,
    input  data_t         b_val,
    input  logic [CW-1:0] a_idx,
    input  logic [CW-1:0] mid,
    input  logic [CW-1:0] b_idx,
    input  logic [CW-1:0] hi,
    output pick_t         pick
);

    logic a_left;
    logic b_left;

    assign a_left = a_idx < mid;
    assign b_left = b_idx < hi;

    // Ties go to run B.
    always_comb
    begin
        pick.take_a = a_left && (!b_left || (a_val < b_val));
        pick.value  = pick.take_a ? a_val : b_val;
    end

endmodule
